[sv/gcrstc_pkg.sv]
package gcrstc_pkg;

  // Sector geometry
  localparam int SECTOR_BYTES = 524;
  localparam int POS_W        = $clog2(SECTOR_BYTES + 1);

  // Field widths
  localparam int NIBBLE_W = 8;
  localparam int BYTE_W   = 8;
  localparam int SUM_W    = 9;
  localparam int HIGH_W   = 6;

  // Position inside a group of four values
  localparam logic [1:0] SLOT_HIGH  = 2'd0;
  localparam logic [1:0] SLOT_BYTE1 = 2'd1;
  localparam logic [1:0] SLOT_BYTE2 = 2'd2;
  localparam logic [1:0] SLOT_BYTE3 = 2'd3;

  // Trailing checksum values, in arrival order
  localparam logic [2:0] CHK_FOLDED = 3'd0;
  localparam logic [2:0] CHK_SUM3   = 3'd1;
  localparam logic [2:0] CHK_SUM2   = 3'd2;
  localparam logic [2:0] CHK_SUM1   = 3'd3;
  localparam logic [2:0] CHK_DONE   = 3'd4;

  typedef struct packed {
    logic [NIBBLE_W-1:0] nibble;
    logic                first;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              is_check;
    logic              check_ok;
  } result_t;

endpackage

[sv/gcrstc_ifs.sv]
// Input channel: one decoded disk value per item
interface gcrstc_in_if import gcrstc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NIBBLE_W-1:0] nibble;
  logic                first;

  modport source (output valid, output nibble, output first, input ready);
  modport sink   (input valid, input nibble, input first, output ready);
endinterface

// Result channel: recovered byte or checksum verdict
interface gcrstc_out_if import gcrstc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              is_check;
  logic              check_ok;

  modport source (output valid, output data_byte, output is_check, output check_ok,
                  input ready);
  modport sink   (input valid, input data_byte, input is_check, input check_ok,
                  output ready);
endinterface

[sv/gcr_sector_triple_checksum_decoder.sv]
// Channel | Dir | Payload                          | Handshake
// in_ch   | in  | nibble[7:0], first               | valid/ready
// out_ch  | out | data_byte[7:0], is_check, check_ok | valid/ready
//
// One item per cycle sustained while the output is not stalled.
// The input register feeds the decode step, whose result lands in the output register.
// An item that gives no result (high-bits value, early checksum values) still moves on.
// Reset (rst_n low, synchronous) empties both registers and clears the sector state.
// A stalled output holds the pipeline; the input register still fills behind it.
module gcr_sector_triple_checksum_decoder import gcrstc_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  gcrstc_in_if.sink    in_ch,
  gcrstc_out_if.source out_ch
);

  logic              in_valid_r;
  item_t             in_item_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] data_byte_r;
  logic              is_check_r;
  logic              check_ok_r;
  logic              advance;
  logic              step;
  result_t           res;

  // Pipeline control
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  gcrstc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.nibble <= in_ch.nibble;
      in_item_r.first  <= in_ch.first;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      data_byte_r <= res.data_byte;
      is_check_r  <= res.is_check;
      check_ok_r  <= res.check_ok;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_byte = data_byte_r;
  assign out_ch.is_check  = is_check_r;
  assign out_ch.check_ok  = check_ok_r;

endmodule

[sv/gcrstc_core.sv]
// Sector decode state and the per-value byte/checksum step.
module gcrstc_core import gcrstc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  logic [POS_W-1:0]  position_r,  position_nxt,  position_cur;
  logic [HIGH_W-1:0] high_bits_r, high_bits_nxt, high_bits_cur;
  logic [SUM_W-1:0]  sum_one_r,   sum_one_nxt,   sum_one_cur;
  logic [SUM_W-1:0]  sum_two_r,   sum_two_nxt,   sum_two_cur;
  logic [SUM_W-1:0]  sum_three_r, sum_three_nxt, sum_three_cur;
  logic              all_match_r, all_match_nxt, all_match_cur;
  logic [1:0]        slot_r,      slot_nxt,      slot_cur;
  logic [2:0]        chk_cnt_r,   chk_cnt_nxt,   chk_cnt_cur;

  logic [BYTE_W-1:0] rebuilt;
  logic [BYTE_W-1:0] rot_one;
  logic [BYTE_W-1:0] val;
  logic [BYTE_W-1:0] expect_val;

  // A first flag starts from cleared state
  always_comb begin
    if (item.first) begin
      position_cur  = '0;
      high_bits_cur = '0;
      sum_one_cur   = '0;
      sum_two_cur   = '0;
      sum_three_cur = '0;
      all_match_cur = 1'b1;
      slot_cur      = SLOT_HIGH;
      chk_cnt_cur   = CHK_FOLDED;
    end else begin
      position_cur  = position_r;
      high_bits_cur = high_bits_r;
      sum_one_cur   = sum_one_r;
      sum_two_cur   = sum_two_r;
      sum_three_cur = sum_three_r;
      all_match_cur = all_match_r;
      slot_cur      = slot_r;
      chk_cnt_cur   = chk_cnt_r;
    end
  end

  // Byte rebuild: two high bits from the group's high-bits value
  always_comb begin
    case (slot_cur)
      SLOT_BYTE1: rebuilt = {high_bits_cur[5:4], item.nibble[5:0]};
      SLOT_BYTE2: rebuilt = {high_bits_cur[3:2], item.nibble[5:0]};
      SLOT_BYTE3: rebuilt = {high_bits_cur[1:0], item.nibble[5:0]};
      default:    rebuilt = {2'b00, item.nibble[5:0]};
    endcase
  end

  assign rot_one = {sum_one_cur[6:0], sum_one_cur[7]};

  // Checksum value expected for each trailing item (folded top bits first)
  always_comb begin
    case (chk_cnt_cur)
      CHK_FOLDED: expect_val = {2'b00, sum_three_cur[7:6], sum_two_cur[7:6],
                                sum_one_cur[7:6]};
      CHK_SUM3:   expect_val = {2'b00, sum_three_cur[5:0]};
      CHK_SUM2:   expect_val = {2'b00, sum_two_cur[5:0]};
      default:    expect_val = {2'b00, sum_one_cur[5:0]};
    endcase
  end

  // Step: data phase, then checksum phase, then idle until next sector
  always_comb begin
    position_nxt  = position_cur;
    high_bits_nxt = high_bits_cur;
    sum_one_nxt   = sum_one_cur;
    sum_two_nxt   = sum_two_cur;
    sum_three_nxt = sum_three_cur;
    all_match_nxt = all_match_cur;
    slot_nxt      = slot_cur;
    chk_cnt_nxt   = chk_cnt_cur;
    val           = '0;
    res           = '0;
    if (position_cur < POS_W'(SECTOR_BYTES)) begin
      if (slot_cur == SLOT_HIGH) begin
        high_bits_nxt = item.nibble[HIGH_W-1:0];
        slot_nxt      = SLOT_BYTE1;
      end else begin
        case (slot_cur)
          SLOT_BYTE1: begin
            val           = rebuilt ^ rot_one;
            sum_three_nxt = sum_three_cur + {1'b0, val} + {8'b0, sum_one_cur[7]};
            sum_one_nxt   = {1'b0, rot_one};
          end
          SLOT_BYTE2: begin
            val           = rebuilt ^ sum_three_cur[7:0];
            sum_two_nxt   = sum_two_cur + {1'b0, val} + {8'b0, sum_three_cur[8]};
            sum_three_nxt = {1'b0, sum_three_cur[7:0]};
          end
          default: begin
            val         = rebuilt ^ sum_two_cur[7:0];
            sum_one_nxt = sum_one_cur + {1'b0, val} + {8'b0, sum_two_cur[8]};
            sum_two_nxt = {1'b0, sum_two_cur[7:0]};
          end
        endcase
        position_nxt  = position_cur + POS_W'(1);
        slot_nxt      = (slot_cur == SLOT_BYTE3) ? SLOT_HIGH : slot_cur + 2'd1;
        res.valid     = 1'b1;
        res.data_byte = val;
      end
    end else if (chk_cnt_cur != CHK_DONE) begin
      all_match_nxt = all_match_cur & (item.nibble == expect_val);
      chk_cnt_nxt   = chk_cnt_cur + 3'd1;
      if (chk_cnt_cur == CHK_SUM1) begin
        res.valid    = 1'b1;
        res.is_check = 1'b1;
        res.check_ok = all_match_nxt;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      high_bits_r <= '0;
      sum_one_r   <= '0;
      sum_two_r   <= '0;
      sum_three_r <= '0;
      all_match_r <= 1'b1;
      slot_r      <= SLOT_HIGH;
      chk_cnt_r   <= CHK_FOLDED;
    end else if (step) begin
      position_r  <= position_nxt;
      high_bits_r <= high_bits_nxt;
      sum_one_r   <= sum_one_nxt;
      sum_two_r   <= sum_two_nxt;
      sum_three_r <= sum_three_nxt;
      all_match_r <= all_match_nxt;
      slot_r      <= slot_nxt;
      chk_cnt_r   <= chk_cnt_nxt;
    end
  end

endmodule
